// ===== rtl/core/fat12ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// fat12ccs_pkg
// Shared types and constants for the FAT12 cluster chain step block.
// ----------------------------------------------------------------------------
`default_nettype none

package fat12ccs_pkg;

  // input word kinds, carried on tuser
  localparam logic FUNC_LOAD      = 1'b0;
  localparam logic FUNC_TRANSLATE = 1'b1;

  // configuration register indexes
  localparam logic REG_DATA_START          = 1'b0;
  localparam logic REG_SECTORS_PER_CLUSTER = 1'b1;

  localparam int CFG_DATA_W   = 32;
  localparam int TBL_INDEX_W  = 13;
  localparam int CLUSTER_W    = 12;
  localparam int SECTOR_W     = 32;
  localparam int SPC_W        = 8;
  // wide enough for any byte position of the largest table
  localparam int POS_W        = 17;

  localparam logic [CLUSTER_W-1:0] CHAIN_END_MIN      = 12'hFF8;
  localparam logic [SECTOR_W-1:0]  FIRST_DATA_CLUSTER = 32'd2;

  typedef struct packed {
    logic [SECTOR_W-1:0] data_start;
    logic [SPC_W-1:0]    sectors_per_cluster;
  } cfg_regs_t;

  typedef struct packed {
    logic                   wr;
    logic                   rd;
    logic [TBL_INDEX_W-1:0] index;
    logic [7:0]             wbyte;
    logic [CLUSTER_W-1:0]   cluster;
  } tbl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/fat12ccs_cfg.sv =====
// ----------------------------------------------------------------------------
// fat12ccs_cfg
// Configuration registers: data start sector and sectors per cluster.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12ccs_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [fat12ccs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output      fat12ccs_pkg::cfg_regs_t              regs
);
  import fat12ccs_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.data_start          <= '0;
      regs.sectors_per_cluster <= SPC_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DATA_START:          regs.data_start          <= cfg_data;
        REG_SECTORS_PER_CLUSTER: regs.sectors_per_cluster <= cfg_data[SPC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fat12ccs_table.sv =====
// ----------------------------------------------------------------------------
// fat12ccs_table
// Allocation table store, split into even and odd byte banks so that the two
// bytes of one 12-bit entry come out in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12ccs_table #(
  parameter int TABLE_BYTES = 8192
) (
  input  wire logic                                clk,
  input  wire fat12ccs_pkg::tbl_cmd_t              cmd,
  output      logic [fat12ccs_pkg::CLUSTER_W-1:0]  entry
);
  import fat12ccs_pkg::*;

  localparam int EVEN_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int ODD_DEPTH  = TABLE_BYTES / 2;
  localparam int EW         = $clog2(EVEN_DEPTH);
  localparam int OW         = $clog2(ODD_DEPTH);
  localparam logic [POS_W-1:0] LIMIT = POS_W'(TABLE_BYTES);

  logic [7:0] even_mem [EVEN_DEPTH];
  logic [7:0] odd_mem  [ODD_DEPTH];

  logic [POS_W-1:0] pos, pos_hi, even_pos, odd_pos, wr_pos;
  logic             even_ok, odd_ok, wr_ok;

  logic [7:0] even_q, odd_q;
  logic       even_ok_q, odd_ok_q, swap_q, odd_cluster_q;

  logic [7:0]  even_byte, odd_byte, lo_byte, hi_byte;
  logic [15:0] word;

  // entry sits at cluster * 3 / 2
  assign pos      = POS_W'(cmd.cluster) + POS_W'(cmd.cluster[CLUSTER_W-1:1]);
  assign pos_hi   = pos + POS_W'(1);
  assign even_pos = pos[0] ? pos_hi : pos;
  assign odd_pos  = pos[0] ? pos : pos_hi;
  assign even_ok  = even_pos < LIMIT;
  assign odd_ok   = odd_pos < LIMIT;

  assign wr_pos = POS_W'(cmd.index);
  assign wr_ok  = wr_pos < LIMIT;

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok && !wr_pos[0]) begin
      even_mem[wr_pos[EW:1]] <= cmd.wbyte;
    end
    if (cmd.rd && even_ok) begin
      even_q <= even_mem[even_pos[EW:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok && wr_pos[0]) begin
      odd_mem[wr_pos[OW:1]] <= cmd.wbyte;
    end
    if (cmd.rd && odd_ok) begin
      odd_q <= odd_mem[odd_pos[OW:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      even_ok_q     <= even_ok;
      odd_ok_q      <= odd_ok;
      swap_q        <= pos[0];
      odd_cluster_q <= cmd.cluster[0];
    end
  end

  // bytes beyond the table read as zero
  assign even_byte = even_ok_q ? even_q : 8'h00;
  assign odd_byte  = odd_ok_q  ? odd_q  : 8'h00;
  assign lo_byte   = swap_q ? odd_byte  : even_byte;
  assign hi_byte   = swap_q ? even_byte : odd_byte;
  assign word      = {hi_byte, lo_byte};
  assign entry     = odd_cluster_q ? word[15:4] : word[11:0];

endmodule

`default_nettype wire

// ===== rtl/core/fat12_cluster_chain_step.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_step
// FAT12 cluster translation: first sector address and next cluster lookup.
// ----------------------------------------------------------------------------
// Load words write one byte of the allocation table; translate words return
// the cluster's first sector (data_start + (cluster - 2) * sectors_per_cluster,
// modulo 2^32), its 12-bit table entry and a chain end flag. One word is taken
// every cycle unless the output is stalled by m_axis_tready. The table
// sits in two single-read-port banks (even and odd bytes), so both bytes of an
// entry come out of one registered read; the multiply is registered alongside
// it and the add and flag go into the output register. No clearing pass after
// reset: table bytes must be loaded before they are looked up.
`default_nettype none

module fat12_cluster_chain_step #(
  parameter int TABLE_BYTES = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // table_index[12:0], table_byte[20:13], cluster[32:21], zero fill
  input  wire logic [39:0] s_axis_tdata,
  // func[0]
  input  wire logic        s_axis_tuser,
  // master side
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // sector_address[31:0], next_cluster[43:32], chain_end[44], zero fill
  output      logic [47:0] m_axis_tdata,
  // configuration
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import fat12ccs_pkg::*;

  cfg_regs_t regs;
  tbl_cmd_t  cmd;

  logic [TBL_INDEX_W-1:0] in_index;
  logic [7:0]             in_byte;
  logic [CLUSTER_W-1:0]   in_cluster;
  logic                   in_fire, is_xlate, out_free;

  logic                   s1_valid;
  logic [SECTOR_W-1:0]    s1_prod;
  logic [SECTOR_W-1:0]    prod_next;
  logic [CLUSTER_W-1:0]   entry;

  logic [SECTOR_W-1:0]    out_sector;
  logic [CLUSTER_W-1:0]   out_next;
  logic                   out_chain_end;

  fat12ccs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  assign in_index   = s_axis_tdata[12:0];
  assign in_byte    = s_axis_tdata[20:13];
  assign in_cluster = s_axis_tdata[32:21];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_xlate      = s_axis_tuser == FUNC_TRANSLATE;

  always_comb begin
    cmd.wr      = in_fire && (s_axis_tuser == FUNC_LOAD);
    cmd.rd      = in_fire && is_xlate;
    cmd.index   = in_index;
    cmd.wbyte   = in_byte;
    cmd.cluster = in_cluster;
  end

  fat12ccs_table #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_table (
    .clk   (clk),
    .cmd   (cmd),
    .entry (entry)
  );

  // clusters 0 and 1 wrap, as the low 32 bits of the product do
  assign prod_next = SECTOR_W'((SECTOR_W'(in_cluster) - FIRST_DATA_CLUSTER)
                              * SECTOR_W'(regs.sectors_per_cluster));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= is_xlate;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      s1_prod <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_sector    <= regs.data_start + s1_prod;
      out_next      <= entry;
      out_chain_end <= entry >= CHAIN_END_MIN;
    end
  end

  assign m_axis_tdata = {3'b000, out_chain_end, out_next, out_sector};

  // a translate word always reaches the middle stage
  assert property (@(posedge clk) disable iff (rst)
    in_fire && is_xlate |=> s1_valid)
    else $error("translate word lost before the output stage");

  // a blocked middle stage keeps its product
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_prod))
    else $error("stalled middle stage changed");

  // a moving middle stage shows up at the output
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free |=> m_axis_tvalid)
    else $error("result dropped between stages");

  // chain end flag agrees with the entry it came with
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_chain_end == (out_next >= CHAIN_END_MIN)))
    else $error("chain end flag inconsistent with next cluster");

endmodule

`default_nettype wire

// ===== bench/fat12_cluster_chain_step_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_chain_step_tb
// Self-checking bench for the FAT12 cluster chain step block.
// ----------------------------------------------------------------------------
// Words are queued by the stimulus process and driven in random bursts; a
// local copy of the allocation table and the two registers predicts every
// translate result, which the monitor checks field by field in order. Only
// clusters whose two table bytes have been loaded are ever translated.

module fat12_cluster_chain_step_tb;
  import fat12ccs_pkg::*;

  localparam int TABLE_BYTES = 8192;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic                   func;
    logic [TBL_INDEX_W-1:0] table_index;
    logic [7:0]             table_byte;
    logic [CLUSTER_W-1:0]   cluster;
  } chain_word_t;

  typedef struct packed {
    logic [SECTOR_W-1:0]  sector_address;
    logic [CLUSTER_W-1:0] next_cluster;
    logic                 chain_end;
  } chain_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  fat12_cluster_chain_step #(
    .TABLE_BYTES(TABLE_BYTES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [7:0]          fat_bytes [TABLE_BYTES];
  logic [SECTOR_W-1:0] cur_data_start = '0;
  logic [SPC_W-1:0]    cur_spc = 8'd1;

  // stimulus-side view of what has been loaded so far
  bit                  loaded [TABLE_BYTES];
  logic [7:0]          planned_bytes [TABLE_BYTES];

  chain_word_t   pend_words [$];
  chain_result_t exp_results [$];
  int            fail_count = 0;
  int            queued = 0;
  int            hold_requests = 0;

  // driver state
  chain_word_t word_on_bus;
  int          burst_left = 0;
  int          gap_left = 0;

  // monitor state
  chain_result_t want;
  int            holds_served = 0;
  int            hold_left = 0;
  int            ready_mode = 0;
  int            mode_left = 0;

  function automatic logic [7:0] fat_byte_at(input logic [POS_W-1:0] pos);
    if (pos >= TABLE_BYTES) return 8'h00;
    return fat_bytes[pos];
  endfunction

  function automatic chain_result_t chain_lookup(input logic [CLUSTER_W-1:0] clus);
    logic [POS_W-1:0]     pos;
    logic [15:0]          pair;
    logic [CLUSTER_W-1:0] nxt;
    chain_result_t        r;
    pos  = POS_W'((POS_W'(clus) * 3) >> 1);
    pair = {fat_byte_at(pos + 1'b1), fat_byte_at(pos)};
    nxt  = clus[0] ? pair[15:4] : pair[11:0];
    r.sector_address = cur_data_start
                     + (SECTOR_W'(clus) - FIRST_DATA_CLUSTER) * SECTOR_W'(cur_spc);
    r.next_cluster   = nxt;
    r.chain_end      = (nxt >= CHAIN_END_MIN);
    return r;
  endfunction

  // stimulus helpers

  task automatic push_load(input int idx, input logic [7:0] b);
    chain_word_t w;
    w.func        = FUNC_LOAD;
    w.table_index = idx[TBL_INDEX_W-1:0];
    w.table_byte  = b;
    w.cluster     = CLUSTER_W'($urandom_range(0, 4095));
    pend_words.push_back(w);
    loaded[idx]        = 1'b1;
    planned_bytes[idx] = b;
    queued++;
  endtask

  task automatic push_translate(input int c);
    chain_word_t w;
    w.func        = FUNC_TRANSLATE;
    w.table_index = TBL_INDEX_W'($urandom_range(0, 8191));
    w.table_byte  = 8'($urandom_range(0, 255));
    w.cluster     = c[CLUSTER_W-1:0];
    pend_words.push_back(w);
    queued++;
  endtask

  // load the two bytes of one entry, keeping the neighbour's nibble
  task automatic set_entry(input int c, input logic [11:0] v);
    int         pos;
    logic [7:0] lo;
    logic [7:0] hi;
    pos = c * 3 / 2;
    lo  = loaded[pos] ? planned_bytes[pos] : 8'h00;
    hi  = loaded[pos + 1] ? planned_bytes[pos + 1] : 8'h00;
    if (c % 2 == 0) begin
      lo = v[7:0];
      hi = {hi[7:4], v[11:8]};
    end else begin
      lo = {v[3:0], lo[3:0]};
      hi = v[11:4];
    end
    push_load(pos, lo);
    push_load(pos + 1, hi);
  endtask

  task automatic ensure_loaded(input int c);
    int pos;
    pos = c * 3 / 2;
    if (!loaded[pos]) push_load(pos, 8'($urandom_range(0, 255)));
    if (!loaded[pos + 1]) push_load(pos + 1, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [11:0] pick_entry();
    case ($urandom_range(0, 5))
      0: return 12'(12'hFF8 + $urandom_range(0, 7));
      1: return 12'h000;
      2: return 12'hFF7;
      3: return 12'hFFF;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic queue_random(input int n);
    int target;
    int c;
    int r;
    target = queued + n;
    while (queued < target) begin
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 95);
      if (r < 20) begin
        push_load($urandom_range(0, 8191), 8'($urandom_range(0, 255)));
      end else if (r < 40) begin
        set_entry(c, pick_entry());
        push_translate(c);
      end else begin
        ensure_loaded(c);
        push_translate(c);
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_DATA_START) cur_data_start = val;
    else cur_spc = val[SPC_W-1:0];
  endtask

  // loads give no result, so allow the pipeline to drain past the last one
  task automatic wait_idle();
    while (pend_words.size() != 0 || exp_results.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] ds, input logic [7:0] spc,
                           input int n, input bit with_hold);
    write_reg(REG_DATA_START, ds);
    write_reg(REG_SECTORS_PER_CLUSTER, {24'h0, spc});
    queue_random(n);
    if (with_hold) hold_requests++;
    wait_idle();
  endtask

  // driver: bursts with random gaps, prediction on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (word_on_bus.func == FUNC_TRANSLATE)
          exp_results.push_back(chain_lookup(word_on_bus.cluster));
        else if (word_on_bus.table_index < TABLE_BYTES)
          fat_bytes[word_on_bus.table_index] = word_on_bus.table_byte;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pend_words.size() != 0) begin
          word_on_bus = pend_words.pop_front();
          s_axis_tdata  <= {7'h00, word_on_bus.cluster, word_on_bus.table_byte,
                            word_on_bus.table_index};
          s_axis_tuser  <= word_on_bus.func;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results in order, ready follows its own pattern
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_results.size() == 0) begin
          $error("result word %h with nothing outstanding", m_axis_tdata);
          fail_count++;
        end else begin
          want = exp_results.pop_front();
          if (m_axis_tdata[31:0] !== want.sector_address) begin
            $error("sector_address: expected %h, got %h",
                   want.sector_address, m_axis_tdata[31:0]);
            fail_count++;
          end
          if (m_axis_tdata[43:32] !== want.next_cluster) begin
            $error("next_cluster: expected %h, got %h",
                   want.next_cluster, m_axis_tdata[43:32]);
            fail_count++;
          end
          if (m_axis_tdata[44] !== want.chain_end) begin
            $error("chain_end: expected %b, got %b", want.chain_end, m_axis_tdata[44]);
            fail_count++;
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < TABLE_BYTES; i++) begin
      fat_bytes[i]     = 8'h00;
      planned_bytes[i] = 8'h00;
      loaded[i]        = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    set_entry(0, 12'hFF8);
    set_entry(1, 12'hFF7);
    push_translate(0);              // address wraps below zero
    push_translate(1);
    set_entry(4095, 12'hFFF);       // last cluster, top of the used table
    push_translate(4095);
    set_entry(2, 12'h000);
    push_translate(2);
    set_entry(3, 12'hABC);
    begin
      chain_word_t w;
      w.func        = FUNC_TRANSLATE;
      w.table_index = 13'h1FFF;     // ignored fields at all ones
      w.table_byte  = 8'hFF;
      w.cluster     = 12'd3;
      pend_words.push_back(w);
      w.func        = FUNC_LOAD;
      w.table_index = 13'h1FFF;     // highest byte index, cluster ignored
      w.table_byte  = 8'hFF;
      w.cluster     = 12'hFFF;
      pend_words.push_back(w);
      w.table_index = 13'h0000;
      w.table_byte  = 8'h00;
      w.cluster     = 12'h000;
      pend_words.push_back(w);
    end
    push_translate(0);
    wait_idle();

    run_phase(32'hFFFF_FFFF, 8'd128, 160, 1'b1);
    push_translate(0);
    push_translate(4095);
    wait_idle();
    run_phase(32'h0000_0000, 8'd0, 140, 1'b0);
    run_phase($urandom, 8'($urandom_range(1, 128)), 160, 1'b1);
    run_phase($urandom, 8'd1, 140, 1'b0);
    run_phase($urandom, 8'd128, 160, 1'b1);
    run_phase(32'h0000_0000, 8'd1, 140, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (exp_results.size() != 0) begin
      $error("%0d results never arrived", exp_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
